[rtl/core/caa_pkg.sv]
`default_nettype none
package caa_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4,
		CMD_MAG = 3'd5,
		CMD_EQ  = 3'd6
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] cmd;
		logic       sign_re;
		logic       sign_im;
		logic       dbz;
		logic       big_re;
		logic       big_im;
		logic       eq;
	} caa_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/caa_in_if.sv]
`default_nettype none
interface caa_in_if #(
	parameter int DATA_WIDTH = caa_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   command;
	logic signed [DATA_WIDTH-1:0] a_re;
	logic signed [DATA_WIDTH-1:0] a_im;
	logic signed [DATA_WIDTH-1:0] b_re;
	logic signed [DATA_WIDTH-1:0] b_im;

	modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface
`default_nettype wire

[rtl/core/caa_out_if.sv]
`default_nettype none
interface caa_out_if #(
	parameter int DATA_WIDTH = caa_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_re;
	logic signed [DATA_WIDTH-1:0] result_im;
	logic                         is_equal;
	logic                         divide_by_zero;
	logic                         overflow;

	modport source (output valid, result_re, result_im, is_equal, divide_by_zero, overflow,
		input ready);
	modport sink (input valid, result_re, result_im, is_equal, divide_by_zero, overflow,
		output ready);
endinterface
`default_nettype wire

[rtl/core/caa_front.sv]
`default_nettype none
module caa_front #(
	parameter int DATA_WIDTH = caa_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = caa_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [2:0]                   command,
	input  wire logic signed [DATA_WIDTH-1:0] a_re,
	input  wire logic signed [DATA_WIDTH-1:0] a_im,
	input  wire logic signed [DATA_WIDTH-1:0] b_re,
	input  wire logic signed [DATA_WIDTH-1:0] b_im,
	output caa_pkg::caa_ctrl_t                ctrl_s2,
	output logic [DATA_WIDTH-1:0]             q_re_s2,
	output logic [DATA_WIDTH-1:0]             q_im_s2,
	output logic [DATA_WIDTH-1:0]             lo_re_s2,
	output logic [DATA_WIDTH-1:0]             lo_im_s2,
	output logic [2*DATA_WIDTH:0]             rem_re_s2,
	output logic [2*DATA_WIDTH:0]             rem_im_s2,
	output logic [2*DATA_WIDTH-1:0]           den_s2,
	output logic [2*DATA_WIDTH-1:0]           rad_s2
);
	import caa_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * DATA_WIDTH;
	localparam int CW = 2 * DATA_WIDTH + FRAC_BITS + 1;
	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	function automatic logic [W:0] sat_narrow(input logic [W:0] v);
		logic [W:0] r;
		if (v[W] != v[W-1]) begin
			r = {1'b1, (v[W] ? MIN_V : MAX_V)};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [W:0] sat_wide(input logic [PW:0] v);
		logic [W:0] r;
		if ((&v[PW:W-1]) || !(|v[PW:W-1])) begin
			r = {1'b0, v[W-1:0]};
		end else begin
			r = {1'b1, (v[PW] ? MIN_V : MAX_V)};
		end
		return r;
	endfunction

	logic signed [W-1:0] sq_x, sq_y;
	logic [W:0]          dir_re_d, dir_im_d;
	logic                eq_d, dbz_d;

	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic [W:0]           dir_re_s1, dir_im_s1;
	logic                 valid_s1, eq_s1, dbz_s1;
	logic [2:0]           cmd_s1;

	always_comb begin
		sq_x = (command == CMD_MAG) ? a_re : b_re;
		sq_y = (command == CMD_MAG) ? a_im : b_im;
		dir_re_d = '0;
		dir_im_d = '0;
		case (command)
			CMD_ADD: begin
				dir_re_d = sat_narrow({a_re[W-1], a_re} + {b_re[W-1], b_re});
				dir_im_d = sat_narrow({a_im[W-1], a_im} + {b_im[W-1], b_im});
			end
			CMD_SUB: begin
				dir_re_d = sat_narrow({a_re[W-1], a_re} - {b_re[W-1], b_re});
				dir_im_d = sat_narrow({a_im[W-1], a_im} - {b_im[W-1], b_im});
			end
			CMD_NEG: begin
				dir_re_d = sat_narrow((W+1)'(0) - {a_re[W-1], a_re});
				dir_im_d = sat_narrow((W+1)'(0) - {a_im[W-1], a_im});
			end
			default: begin
				dir_re_d = '0;
				dir_im_d = '0;
			end
		endcase
		eq_d  = (command == CMD_EQ) && (a_re == b_re) && (a_im == b_im);
		dbz_d = (command == CMD_DIV) && (b_re == '0) && (b_im == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1     <= a_re * b_re;
			p1_s1     <= a_im * b_im;
			p2_s1     <= a_re * b_im;
			p3_s1     <= a_im * b_re;
			p4_s1     <= sq_x * sq_x;
			p5_s1     <= sq_y * sq_y;
			dir_re_s1 <= dir_re_d;
			dir_im_s1 <= dir_im_d;
			cmd_s1    <= command;
			eq_s1     <= eq_d;
			dbz_s1    <= dbz_d;
		end
	end

	logic [PW:0]   mul_re, mul_im, nr, ni, mre_sh, mim_sh;
	logic [W:0]    mre_sat, mim_sat;
	logic [PW-1:0] abs_re, abs_im, den;
	logic [CW-1:0] ns_re, ns_im, hi_re, hi_im;
	logic          big_re_d, big_im_d;
	caa_ctrl_t     ctrl_d;
	logic [W-1:0]  q_re_d, q_im_d;

	always_comb begin
		mul_re = {p0_s1[PW-1], p0_s1} - {p1_s1[PW-1], p1_s1};
		mul_im = {p2_s1[PW-1], p2_s1} + {p3_s1[PW-1], p3_s1};
		mre_sh = $unsigned($signed(mul_re) >>> FRAC_BITS);
		mim_sh = $unsigned($signed(mul_im) >>> FRAC_BITS);
		mre_sat = sat_wide(mre_sh);
		mim_sat = sat_wide(mim_sh);
		nr = {p0_s1[PW-1], p0_s1} + {p1_s1[PW-1], p1_s1};
		ni = {p3_s1[PW-1], p3_s1} - {p2_s1[PW-1], p2_s1};
		abs_re = nr[PW] ? PW'((PW+1)'(0) - nr) : nr[PW-1:0];
		abs_im = ni[PW] ? PW'((PW+1)'(0) - ni) : ni[PW-1:0];
		ns_re = CW'(abs_re) << FRAC_BITS;
		ns_im = CW'(abs_im) << FRAC_BITS;
		hi_re = ns_re >> W;
		hi_im = ns_im >> W;
		den = $unsigned(p4_s1) + $unsigned(p5_s1);
		big_re_d = hi_re >= CW'(den);
		big_im_d = hi_im >= CW'(den);

		ctrl_d.valid   = valid_s1;
		ctrl_d.cmd     = cmd_s1;
		ctrl_d.sign_re = nr[PW];
		ctrl_d.sign_im = ni[PW];
		ctrl_d.dbz     = dbz_s1;
		ctrl_d.eq      = eq_s1;
		case (cmd_s1)
			CMD_MUL: begin
				ctrl_d.big_re = mre_sat[W];
				ctrl_d.big_im = mim_sat[W];
				q_re_d = mre_sat[W-1:0];
				q_im_d = mim_sat[W-1:0];
			end
			CMD_DIV: begin
				ctrl_d.big_re = big_re_d;
				ctrl_d.big_im = big_im_d;
				q_re_d = '0;
				q_im_d = '0;
			end
			default: begin
				ctrl_d.big_re = dir_re_s1[W];
				ctrl_d.big_im = dir_im_s1[W];
				q_re_d = dir_re_s1[W-1:0];
				q_im_d = dir_im_s1[W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_re_s2   <= q_re_d;
			q_im_s2   <= q_im_d;
			lo_re_s2  <= ns_re[W-1:0];
			lo_im_s2  <= ns_im[W-1:0];
			rem_re_s2 <= big_re_d ? '0 : hi_re[PW:0];
			rem_im_s2 <= big_im_d ? '0 : hi_im[PW:0];
			den_s2    <= den;
			rad_s2    <= den;
		end
	end

endmodule
`default_nettype wire

[rtl/core/caa_cell.sv]
`default_nettype none
module caa_cell #(
	parameter int DATA_WIDTH = caa_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire caa_pkg::caa_ctrl_t      ctrl_i,
	input  wire logic [DATA_WIDTH-1:0]   q_re_i,
	input  wire logic [DATA_WIDTH-1:0]   q_im_i,
	input  wire logic [DATA_WIDTH-1:0]   lo_re_i,
	input  wire logic [DATA_WIDTH-1:0]   lo_im_i,
	input  wire logic [2*DATA_WIDTH:0]   rem_re_i,
	input  wire logic [2*DATA_WIDTH:0]   rem_im_i,
	input  wire logic [2*DATA_WIDTH-1:0] den_i,
	input  wire logic [2*DATA_WIDTH-1:0] rad_i,
	input  wire logic [DATA_WIDTH+1:0]   sq_rem_i,
	output caa_pkg::caa_ctrl_t           ctrl_q,
	output logic [DATA_WIDTH-1:0]        q_re_q,
	output logic [DATA_WIDTH-1:0]        q_im_q,
	output logic [DATA_WIDTH-1:0]        lo_re_q,
	output logic [DATA_WIDTH-1:0]        lo_im_q,
	output logic [2*DATA_WIDTH:0]        rem_re_q,
	output logic [2*DATA_WIDTH:0]        rem_im_q,
	output logic [2*DATA_WIDTH-1:0]      den_q,
	output logic [2*DATA_WIDTH-1:0]      rad_q,
	output logic [DATA_WIDTH+1:0]        sq_rem_q
);
	import caa_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int RW = 2 * DATA_WIDTH + 1;

	logic [RW-1:0] sh_re, sh_im, den_x;
	logic          ge_re, ge_im, ge_sq;
	logic [W+1:0]  sq_sh, trial;
	logic [W-1:0]  q_re_d, q_im_d;
	logic [RW-1:0] rem_re_d, rem_im_d;
	logic [W+1:0]  sq_rem_d;

	always_comb begin
		den_x = {1'b0, den_i};
		sh_re = {rem_re_i[RW-2:0], lo_re_i[W-1]};
		sh_im = {rem_im_i[RW-2:0], lo_im_i[W-1]};
		ge_re = sh_re >= den_x;
		ge_im = sh_im >= den_x;
		sq_sh = {sq_rem_i[W-1:0], rad_i[2*W-1:2*W-2]};
		trial = {q_re_i, 2'b01};
		ge_sq = sq_sh >= trial;
		q_re_d   = q_re_i;
		q_im_d   = q_im_i;
		rem_re_d = rem_re_i;
		rem_im_d = rem_im_i;
		sq_rem_d = sq_rem_i;
		case (ctrl_i.cmd)
			CMD_DIV: begin
				q_re_d   = {q_re_i[W-2:0], ge_re};
				q_im_d   = {q_im_i[W-2:0], ge_im};
				rem_re_d = ge_re ? (sh_re - den_x) : sh_re;
				rem_im_d = ge_im ? (sh_im - den_x) : sh_im;
			end
			CMD_MAG: begin
				q_re_d   = {q_re_i[W-2:0], ge_sq};
				sq_rem_d = ge_sq ? (sq_sh - trial) : sq_sh;
			end
			default: begin
				q_re_d = q_re_i;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_re_q   <= q_re_d;
			q_im_q   <= q_im_d;
			lo_re_q  <= lo_re_i << 1;
			lo_im_q  <= lo_im_i << 1;
			rem_re_q <= rem_re_d;
			rem_im_q <= rem_im_d;
			den_q    <= den_i;
			rad_q    <= rad_i << 2;
			sq_rem_q <= sq_rem_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/complex_arithmetic_unit.sv]
// Pipeline: the front registers s1 and s2, the chain of digit cells, then the output register.
// Throughput: one word per cycle while the output is not stalled; the chain of DATA_WIDTH digit cells yields one
// quotient bit and one root bit per cell, so every cell holds a different word.
// The whole pipeline holds while the output word waits and is not taken.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
`default_nettype none
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = caa_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = caa_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	caa_in_if.sink   req,
	caa_out_if.source rsp
);
	import caa_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * DATA_WIDTH;
	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	logic en;
	logic out_valid_q;

	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;

	caa_ctrl_t       ctrl_c   [0:W];
	logic [W-1:0]    q_re_c   [0:W];
	logic [W-1:0]    q_im_c   [0:W];
	logic [W-1:0]    lo_re_c  [0:W];
	logic [W-1:0]    lo_im_c  [0:W];
	logic [PW:0]     rem_re_c [0:W];
	logic [PW:0]     rem_im_c [0:W];
	logic [PW-1:0]   den_c    [0:W];
	logic [PW-1:0]   rad_c    [0:W];
	logic [W+1:0]    sq_rem_c [0:W];

	assign sq_rem_c[0] = '0;

	caa_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req.valid),
		.command  (req.command),
		.a_re     (req.a_re),
		.a_im     (req.a_im),
		.b_re     (req.b_re),
		.b_im     (req.b_im),
		.ctrl_s2  (ctrl_c[0]),
		.q_re_s2  (q_re_c[0]),
		.q_im_s2  (q_im_c[0]),
		.lo_re_s2 (lo_re_c[0]),
		.lo_im_s2 (lo_im_c[0]),
		.rem_re_s2(rem_re_c[0]),
		.rem_im_s2(rem_im_c[0]),
		.den_s2   (den_c[0]),
		.rad_s2   (rad_c[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_cell
		caa_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctrl_i  (ctrl_c[i]),
			.q_re_i  (q_re_c[i]),
			.q_im_i  (q_im_c[i]),
			.lo_re_i (lo_re_c[i]),
			.lo_im_i (lo_im_c[i]),
			.rem_re_i(rem_re_c[i]),
			.rem_im_i(rem_im_c[i]),
			.den_i   (den_c[i]),
			.rad_i   (rad_c[i]),
			.sq_rem_i(sq_rem_c[i]),
			.ctrl_q  (ctrl_c[i+1]),
			.q_re_q  (q_re_c[i+1]),
			.q_im_q  (q_im_c[i+1]),
			.lo_re_q (lo_re_c[i+1]),
			.lo_im_q (lo_im_c[i+1]),
			.rem_re_q(rem_re_c[i+1]),
			.rem_im_q(rem_im_c[i+1]),
			.den_q   (den_c[i+1]),
			.rad_q   (rad_c[i+1]),
			.sq_rem_q(sq_rem_c[i+1])
		);
	end

	function automatic logic [W:0] div_fix(input logic sign, input logic big,
		input logic [W-1:0] q);
		logic [W:0] r;
		if (big) begin
			r = {1'b1, (sign ? MIN_V : MAX_V)};
		end else if (sign) begin
			r = (q > MIN_V) ? {1'b1, MIN_V} : {1'b0, W'(-q)};
		end else begin
			r = (q > MAX_V) ? {1'b1, MAX_V} : {1'b0, q};
		end
		return r;
	endfunction

	caa_ctrl_t  fin;
	logic [W:0] fre, fim;

	always_comb begin
		fin = ctrl_c[W];
		case (fin.cmd)
			CMD_DIV: begin
				if (fin.dbz) begin
					fre = '0;
					fim = '0;
				end else begin
					fre = div_fix(fin.sign_re, fin.big_re, q_re_c[W]);
					fim = div_fix(fin.sign_im, fin.big_im, q_im_c[W]);
				end
			end
			CMD_MAG: begin
				fre = (q_re_c[W] > MAX_V) ? {1'b1, MAX_V} : {1'b0, q_re_c[W]};
				fim = '0;
			end
			default: begin
				fre = {fin.big_re, q_re_c[W]};
				fim = {fin.big_im, q_im_c[W]};
			end
		endcase
	end

	logic [W-1:0] res_re_q, res_im_q;
	logic         eq_q, dbz_q, ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= fre[W-1:0];
			res_im_q <= fim[W-1:0];
			eq_q     <= fin.eq;
			dbz_q    <= fin.dbz;
			ovf_q    <= fre[W] || fim[W];
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_re      = res_re_q;
	assign rsp.result_im      = res_im_q;
	assign rsp.is_equal       = eq_q;
	assign rsp.divide_by_zero = dbz_q;
	assign rsp.overflow       = ovf_q;

endmodule
`default_nettype wire

[rtl/core/caa_checker.sv]
`default_nettype none
module caa_checker #(
	parameter int DATA_WIDTH = caa_pkg::DATA_WIDTH_DEF
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [DATA_WIDTH-1:0] result_re,
	input wire logic [DATA_WIDTH-1:0] result_im,
	input wire logic                  is_equal,
	input wire logic                  divide_by_zero,
	input wire logic                  overflow
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output word dropped while stalled.");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_re) && $stable(result_im)
		&& $stable(overflow))
		else $error("Output word changed while stalled.");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_re == '0 && result_im == '0 && !overflow)
		else $error("Division by zero gave a nonzero result.");

	a_eq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_equal |-> result_re == '0 && result_im == '0 && !overflow
		&& !divide_by_zero)
		else $error("Equality word carries other results.");

endmodule

bind complex_arithmetic_unit caa_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_caa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.result_re     (rsp.result_re),
	.result_im     (rsp.result_im),
	.is_equal      (rsp.is_equal),
	.divide_by_zero(rsp.divide_by_zero),
	.overflow      (rsp.overflow)
);
`default_nettype wire

[test/tb_complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
	import caa_pkg::*;

	localparam int WIDTH = 32;
	localparam int FRAC = 16;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int ITEMS = 950;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic signed [WIDTH-1:0] MAX_VAL = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic signed [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic signed [WIDTH-1:0] ONE_VAL = 1 <<< FRAC;

	typedef struct {
		logic signed [WIDTH-1:0] re;
		logic signed [WIDTH-1:0] im;
		logic                    eq;
		logic                    dbz;
		logic                    ovf;
	} cplx_result_t;

	function automatic logic signed [WIDTH-1:0] clamp(input logic signed [127:0] v,
		inout logic ovf);
		if (v > 128'(signed'(MAX_VAL))) begin
			ovf = 1'b1;
			return MAX_VAL;
		end else if (v < 128'(signed'(MIN_VAL))) begin
			ovf = 1'b1;
			return MIN_VAL;
		end
		return v[WIDTH-1:0];
	endfunction

	function automatic cplx_result_t complex_op(input logic [2:0] cmd,
		input logic signed [WIDTH-1:0] ar, ai, br, bi);
		logic signed [127:0] xr, xi, yr, yi, re, im, den;
		logic [127:0] rad, root, trial;
		cplx_result_t r;
		xr = ar;
		xi = ai;
		yr = br;
		yi = bi;
		re = 0;
		im = 0;
		r.eq = 1'b0;
		r.dbz = 1'b0;
		r.ovf = 1'b0;
		case (cmd)
			CMD_ADD: begin
				re = xr + yr;
				im = xi + yi;
			end
			CMD_SUB: begin
				re = xr - yr;
				im = xi - yi;
			end
			CMD_MUL: begin
				re = (xr * yr - xi * yi) >>> FRAC;
				im = (xr * yi + xi * yr) >>> FRAC;
			end
			CMD_DIV: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.dbz = 1'b1;
				end else begin
					re = ((xr * yr + xi * yi) <<< FRAC) / den;
					im = ((yr * xi - xr * yi) <<< FRAC) / den;
				end
			end
			CMD_NEG: begin
				re = -xr;
				im = -xi;
			end
			CMD_MAG: begin
				rad = xr * xr + xi * xi;
				root = 0;
				for (int k = WIDTH; k >= 0; k--) begin
					trial = root | (128'd1 << k);
					if (trial * trial <= rad)
						root = trial;
				end
				re = root;
			end
			CMD_EQ: begin
				r.eq = (ar == br) && (ai == bi);
			end
			default: begin
			end
		endcase
		r.re = clamp(re, r.ovf);
		r.im = clamp(im, r.ovf);
		return r;
	endfunction

	class result_scoreboard;
		cplx_result_t pending[$];
		int errors;
		int checked;
		int per_cmd[8];
		int overflows;
		int zero_divs;

		function void note_input(logic [2:0] cmd, logic signed [WIDTH-1:0] ar, ai, br, bi);
			cplx_result_t r;
			r = complex_op(cmd, ar, ai, br, bi);
			pending.push_back(r);
			per_cmd[cmd]++;
			if (r.ovf)
				overflows++;
			if (r.dbz)
				zero_divs++;
		endfunction

		function void check_result(cplx_result_t got);
			cplx_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word re=%h im=%h", $time, got.re, got.im);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got.re !== exp_r.re) begin
				$display("%0t: result_re expected %h actual %h", $time, exp_r.re, got.re);
				errors++;
			end
			if (got.im !== exp_r.im) begin
				$display("%0t: result_im expected %h actual %h", $time, exp_r.im, got.im);
				errors++;
			end
			if (got.eq !== exp_r.eq) begin
				$display("%0t: is_equal expected %b actual %b", $time, exp_r.eq, got.eq);
				errors++;
			end
			if (got.dbz !== exp_r.dbz) begin
				$display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dbz,
					got.dbz);
				errors++;
			end
			if (got.ovf !== exp_r.ovf) begin
				$display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int idle_cycles;
	result_scoreboard sb;

	caa_in_if #(.DATA_WIDTH(WIDTH)) req_if();
	caa_out_if #(.DATA_WIDTH(WIDTH)) rsp_if();

	complex_arithmetic_unit #(.DATA_WIDTH(WIDTH), .FRAC_BITS(FRAC)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic signed [WIDTH-1:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? MAX_VAL : MIN_VAL;
			1: return $signed($urandom_range(0, 8 << FRAC)) - (4 <<< FRAC);
			2: return $signed($urandom_range(0, 512)) - 256;
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [2:0] cmd, input logic signed [WIDTH-1:0] ar, ai,
		br, bi);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.command <= cmd;
		req_if.a_re <= ar;
		req_if.a_im <= ai;
		req_if.b_re <= br;
		req_if.b_im <= bi;
		do @(posedge clk); while (!req_if.ready);
		sb.note_input(cmd, ar, ai, br, bi);
	endtask

	task automatic receive_words();
		int gap;
		cplx_result_t got;
		forever begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			got.re = rsp_if.result_re;
			got.im = rsp_if.result_im;
			got.eq = rsp_if.is_equal;
			got.dbz = rsp_if.divide_by_zero;
			got.ovf = rsp_if.overflow;
			sb.check_result(got);
		end
	endtask

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [2:0] cmd;
		logic signed [WIDTH-1:0] ar, ai, br, bi;
		sb = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		req_if.valid <= 1'b0;
		req_if.command <= CMD_ADD;
		req_if.a_re <= 0;
		req_if.a_im <= 0;
		req_if.b_re <= 0;
		req_if.b_im <= 0;
		rsp_if.ready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			receive_words();
		join_none

		send_word(CMD_ADD, MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL);
		send_word(CMD_ADD, ONE_VAL, -ONE_VAL, ONE_VAL, ONE_VAL);
		send_word(CMD_SUB, MIN_VAL, MAX_VAL, MAX_VAL, MIN_VAL);
		send_word(CMD_SUB, 0, 0, 0, 0);
		send_word(CMD_MUL, MAX_VAL, MAX_VAL, MAX_VAL, MIN_VAL);
		send_word(CMD_MUL, ONE_VAL, ONE_VAL, -ONE_VAL, ONE_VAL);
		send_word(CMD_MUL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
		send_word(CMD_MUL, -1, 0, 1, 0);
		send_word(CMD_DIV, ONE_VAL, ONE_VAL, 0, 0);
		send_word(CMD_DIV, MAX_VAL, MIN_VAL, 1, 0);
		send_word(CMD_DIV, ONE_VAL, 0, 0, ONE_VAL);
		send_word(CMD_DIV, -ONE_VAL, 3, 3 * ONE_VAL, -7);
		send_word(CMD_DIV, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
		send_word(CMD_NEG, MIN_VAL, MAX_VAL, 0, 0);
		send_word(CMD_NEG, ONE_VAL, 0, 0, 0);
		send_word(CMD_MAG, MIN_VAL, MIN_VAL, 0, 0);
		send_word(CMD_MAG, MAX_VAL, 0, 0, 0);
		send_word(CMD_MAG, 3 * ONE_VAL, 4 * ONE_VAL, 0, 0);
		send_word(CMD_MAG, 0, 0, 0, 0);
		send_word(CMD_EQ, MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL);
		send_word(CMD_EQ, ONE_VAL, 0, ONE_VAL, 1);
		send_word(CMD_EQ, 0, 0, 0, 0);
		send_word(CMD_UNUSED, MAX_VAL, MIN_VAL, ONE_VAL, -1);

		for (int i = 0; i < ITEMS; i++) begin
			cmd = $urandom_range(0, 7);
			ar = pick_operand();
			ai = pick_operand();
			br = pick_operand();
			bi = pick_operand();
			if (cmd == CMD_EQ && $urandom_range(0, 1)) begin
				br = ar;
				bi = ai;
				if ($urandom_range(0, 1))
					bi[$urandom_range(0, WIDTH - 1)] ^= 1'b1;
			end
			if (cmd == CMD_DIV && $urandom_range(0, 7) == 0) begin
				br = 0;
				bi = 0;
			end
			send_word(cmd, ar, ai, br, bi);
		end
		req_if.valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d, neg %0d, mag %0d,",
			sb.checked, sb.per_cmd[CMD_ADD], sb.per_cmd[CMD_SUB], sb.per_cmd[CMD_MUL],
			sb.per_cmd[CMD_DIV], sb.per_cmd[CMD_NEG], sb.per_cmd[CMD_MAG]);
		$display("eq %0d, unused %0d; %0d saturated and %0d zero divisors; %0d errors.",
			sb.per_cmd[CMD_EQ], sb.per_cmd[CMD_UNUSED], sb.overflows, sb.zero_divs,
			sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
